// ===== sv/hbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the Huffman code bit packer: field widths,
// command codes, code table entry layout and internal packing widths.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int MAX_CODE_LEN = 10;
   localparam int NUM_SYMBOLS  = 256;

   localparam int CMD_W  = 2;
   localparam int SYM_W  = 8;
   localparam int VAL_W  = 10;
   localparam int LEN_W  = 4;
   localparam int BYTE_W = 8;
   localparam int PEND_W = 7;

   localparam int LEN_LIMIT = (MAX_CODE_LEN > 15) ? 15 : MAX_CODE_LEN;
   localparam int IDX_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int ACC_W     = PEND_W + LEN_LIMIT;
   localparam int WORK_W    = (ACC_W > VAL_W) ? ACC_W : VAL_W;
   localparam int CNT_W     = $clog2(PEND_W + LEN_LIMIT + 1);
   localparam int PCNT_W    = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } tbl_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } tbl_rd_type;

endpackage
`default_nettype wire

// ===== sv/huffman_code_bit_packer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Table-driven Huffman encoder that packs codes most significant bit first
// into a byte stream.
// ----------------------------------------------------------------------------
// An item is accepted in every cycle while the result queue has room for
// two bytes. The code table read is registered on the table memory's read
// port, and result bytes pass through the result queue before they appear
// on the result channel. An encode item gives up to two bytes and the
// result channel moves one byte per cycle while rsp_tready is high, so items
// giving at most one byte are taken one item per cycle; when every item
// gives two bytes, the result channel limits the item rate. The table is
// cleared by per-entry valid bits at reset, with no clearing pass.
module huffman_code_bit_packer_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,  // symbol[7:0], code_value[17:8], code_length[21:18]
   input  wire  [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast
);

   typedef struct packed {
      logic [hbp_pkg::BYTE_W-1:0] data;
      logic                       last;
   } out_type;

   logic                           accept;
   hbp_pkg::cmd_type               req_cmd;
   logic [hbp_pkg::SYM_W-1:0]      req_sym;
   logic [hbp_pkg::VAL_W-1:0]      req_val;
   logic [hbp_pkg::LEN_W-1:0]      req_len;
   logic                           req_in_range;
   hbp_pkg::tbl_wr_type            tbl_wr;
   hbp_pkg::tbl_rd_type            tbl_rd;
   hbp_pkg::entry_type             tbl_entry;

   logic                           s1_valid_ff;
   hbp_pkg::cmd_type               s1_cmd_ff;
   logic                           s1_fire;

   logic [hbp_pkg::PEND_W-1:0]     pend_bits_ff, pend_bits_in;
   logic [hbp_pkg::PCNT_W-1:0]     pend_cnt_ff, pend_cnt_in;

   logic [hbp_pkg::LEN_W-1:0]      clen;
   logic [hbp_pkg::WORK_W-1:0]     cval;
   logic [hbp_pkg::WORK_W-1:0]     acc;
   logic [hbp_pkg::CNT_W-1:0]      cnt;
   logic [hbp_pkg::CNT_W-1:0]      rem;
   logic [1:0]                     nbytes;
   logic [hbp_pkg::BYTE_W-1:0]     byte_hi, byte_lo, flush_byte;

   logic [1:0]                     push_n;
   out_type                        push0, push1;
   logic                           pop;

   out_type                        fifo_ff [hbp_pkg::FIFO_DEPTH];
   logic [hbp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [hbp_pkg::FIFO_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;

   assign accept  = req_tvalid && req_tready;
   assign req_cmd = hbp_pkg::cmd_type'(req_tuser);
   assign req_sym = req_tdata[7:0];
   assign req_val = req_tdata[17:8];
   assign req_len = req_tdata[21:18];
   assign req_in_range = ({1'b0, req_sym} < (hbp_pkg::SYM_W+1)'(hbp_pkg::NUM_SYMBOLS));

   always_comb begin
      tbl_wr.en          = accept && (req_cmd == hbp_pkg::CMD_LOAD) && req_in_range;
      tbl_wr.idx         = req_sym[hbp_pkg::IDX_W-1:0];
      tbl_wr.entry.value = req_val;
      tbl_wr.entry.len   = (req_len > hbp_pkg::LEN_W'(hbp_pkg::LEN_LIMIT))
                           ? hbp_pkg::LEN_W'(hbp_pkg::LEN_LIMIT) : req_len;
      tbl_rd.en          = accept && (req_cmd == hbp_pkg::CMD_ENCODE) && req_in_range;
      tbl_rd.idx         = req_sym[hbp_pkg::IDX_W-1:0];
   end

   hbp_code_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .rd       (tbl_rd),
      .rd_entry (tbl_entry)
   );

   logic s1_hit_ff;

   assign s1_fire    = s1_valid_ff
                       && (fifo_cnt_ff <= hbp_pkg::FIFO_CNT_W'(hbp_pkg::FIFO_DEPTH - 2));
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (accept) begin
         s1_cmd_ff <= req_cmd;
         s1_hit_ff <= req_in_range;
      end
   end

   always_comb begin
      clen    = s1_hit_ff ? tbl_entry.len : '0;
      cval    = hbp_pkg::WORK_W'(tbl_entry.value)
                & ((hbp_pkg::WORK_W'(1) << clen) - hbp_pkg::WORK_W'(1));
      acc     = (hbp_pkg::WORK_W'(pend_bits_ff) << clen) | cval;
      cnt     = hbp_pkg::CNT_W'(pend_cnt_ff) + hbp_pkg::CNT_W'(clen);
      byte_hi = hbp_pkg::BYTE_W'(acc >> (cnt - hbp_pkg::CNT_W'(8)));
      byte_lo = hbp_pkg::BYTE_W'(acc >> (cnt - hbp_pkg::CNT_W'(16)));
      if (32'(cnt) >= 32'd16) begin
         nbytes = 2'd2;
         rem    = cnt - hbp_pkg::CNT_W'(16);
      end else if (32'(cnt) >= 32'd8) begin
         nbytes = 2'd1;
         rem    = cnt - hbp_pkg::CNT_W'(8);
      end else begin
         nbytes = 2'd0;
         rem    = cnt;
      end
      flush_byte = hbp_pkg::BYTE_W'(hbp_pkg::BYTE_W'(pend_bits_ff)
                   << (4'd8 - 4'(pend_cnt_ff)));

      push_n       = 2'd0;
      push0        = '0;
      push1        = '0;
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      case (s1_cmd_ff)
         hbp_pkg::CMD_ENCODE: begin
            push_n       = nbytes;
            push0.data   = byte_hi;
            push0.last   = (nbytes == 2'd1);
            push1.data   = byte_lo;
            push1.last   = 1'b1;
            pend_bits_in = hbp_pkg::PEND_W'(acc
                           & ((hbp_pkg::WORK_W'(1) << rem) - hbp_pkg::WORK_W'(1)));
            pend_cnt_in  = hbp_pkg::PCNT_W'(rem);
         end
         hbp_pkg::CMD_FLUSH: begin
            push_n       = (pend_cnt_ff != '0) ? 2'd1 : 2'd0;
            push0.data   = flush_byte;
            push0.last   = 1'b1;
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end
         default: begin
            push_n = 2'd0;
         end
      endcase
      if (!s1_fire) begin
         push_n       = 2'd0;
         pend_bits_in = pend_bits_ff;
         pend_cnt_in  = pend_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

   assign pop         = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + hbp_pkg::FIFO_CNT_W'(push_n)
                        - hbp_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + hbp_pkg::FIFO_PTR_W'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_ff + hbp_pkg::FIFO_PTR_W'(push_n);
         rd_ptr_ff   <= rd_ptr_ff + hbp_pkg::FIFO_PTR_W'(pop);
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   assign rsp_tvalid = (fifo_cnt_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].data;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= hbp_pkg::FIFO_CNT_W'(hbp_pkg::FIFO_DEPTH))
      else $error("result queue holds more items than its depth");

   a_fire_room: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> fifo_cnt_ff <= hbp_pkg::FIFO_CNT_W'(hbp_pkg::FIFO_DEPTH))
      else $error("result queue overflowed after a push");

   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      (pend_bits_ff >> pend_cnt_ff) == '0)
      else $error("pending bits hold ones above the pending count");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !s1_valid_ff)
      else $error("block not idle after reset");
`endif

endmodule
`default_nettype wire

// ===== sv/hbp_code_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_code_table
// Code table memory with one write and one registered read port. A valid
// bit per entry makes every entry read as zero length until it is loaded.
// ----------------------------------------------------------------------------
module hbp_code_table (
   input  wire                  clock,
   input  wire                  reset,
   input  hbp_pkg::tbl_wr_type  wr,
   input  hbp_pkg::tbl_rd_type  rd,
   output hbp_pkg::entry_type   rd_entry
);

   hbp_pkg::entry_type             mem [hbp_pkg::NUM_SYMBOLS];
   logic [hbp_pkg::NUM_SYMBOLS-1:0] loaded_ff;
   hbp_pkg::entry_type             rd_data_ff;
   logic                           rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            loaded_ff[wr.idx] <= 1'b1;
         end
         if (rd.en) begin
            rd_hit_ff <= loaded_ff[rd.idx];
         end
      end
   end

   assign rd_entry = rd_hit_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the Huffman code bit packer. A short table of
// directed items, most with their expected bytes, covers the field extremes,
// every command and the special cases. Random items of all four commands follow
// in three phases with different idle patterns; a behavioral packer predicts them.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int         ITEMS_PER_PHASE = 534;
   localparam int         CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] sym;
      logic [9:0] code_val;
      logic [3:0] code_len;
      logic       typed;
      logic [1:0] n_exp;
      logic [7:0] exp0;
      logic [7:0] exp1;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [23:0] req_tdata = '0;   // symbol[7:0], code_value[17:8], code_length[21:18]
   logic [1:0]  req_tuser = '0;   // command[1:0]
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;        // out_byte[7:0]
   wire         rsp_tlast;

   int          cycle_count = 0;
   int          failures = 0;
   int          send_idle_pct = 31;
   int          recv_idle_pct = 52;
   rsp_type     expected_bytes [$];

   hbp_pkg::entry_type code_mem [hbp_pkg::NUM_SYMBOLS];
   logic [6:0]  pend_bits = '0;
   int          pend_cnt = 0;

   stim_row_type directed_rows [25];

   huffman_code_bit_packer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic stim_row_type make_row(input logic [1:0] cmd, input logic [7:0] sym,
                                             input logic [9:0] code_val,
                                             input logic [3:0] code_len, input logic typed,
                                             input logic [1:0] n_exp, input logic [7:0] exp0,
                                             input logic [7:0] exp1);
      stim_row_type r;
      r.cmd      = cmd;
      r.sym      = sym;
      r.code_val = code_val;
      r.code_len = code_len;
      r.typed    = typed;
      r.n_exp    = n_exp;
      r.exp0     = exp0;
      r.exp1     = exp1;
      return r;
   endfunction

   // Updates the table and the bit accumulator for one item and returns the
   // number of bytes that it completes, with the bytes in outs.
   function automatic int pack_code_bits(input stim_row_type s, output rsp_type [1:0] outs);
      hbp_pkg::entry_type ent;
      logic [3:0]  clen;
      logic [16:0] acc;
      int          cnt;
      int          n;
      n = 0;
      outs = '0;
      case (s.cmd)
         hbp_pkg::CMD_LOAD: begin
            clen = (s.code_len > hbp_pkg::LEN_LIMIT) ? 4'(hbp_pkg::LEN_LIMIT) : s.code_len;
            code_mem[s.sym].len   = clen;
            code_mem[s.sym].value = s.code_val;
         end
         hbp_pkg::CMD_ENCODE: begin
            ent = code_mem[s.sym];
            acc = (17'(pend_bits) << ent.len)
                  | (17'(ent.value) & ((17'd1 << ent.len) - 17'd1));
            cnt = pend_cnt + int'(ent.len);
            while (cnt >= 8) begin
               outs[n].data = 8'(acc >> (cnt - 8));
               outs[n].last = 1'b0;
               n++;
               cnt -= 8;
            end
            pend_bits = 7'(acc & ((17'd1 << cnt) - 17'd1));
            pend_cnt  = cnt;
            if (n > 0) outs[n-1].last = 1'b1;
         end
         hbp_pkg::CMD_FLUSH: begin
            if (pend_cnt != 0) begin
               outs[0].data = 8'({1'b0, pend_bits} << (8 - pend_cnt));
               outs[0].last = 1'b1;
               n = 1;
            end
            pend_bits = '0;
            pend_cnt  = 0;
         end
         default: begin
         end
      endcase
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      failures++;
   endtask

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance.
   task automatic send_item(input stim_row_type s);
      rsp_type [1:0] outs;
      int            n;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.cmd;
      req_tdata  <= {2'b00, s.code_len, s.code_val, s.sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n = pack_code_bits(s, outs);
      if (s.typed) begin
         n = int'(s.n_exp);
         outs[0].data = s.exp0;
         outs[0].last = (s.n_exp == 2'd1);
         outs[1].data = s.exp1;
         outs[1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) expected_bytes.push_back(outs[i]);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b", rsp_tlast, want.last));
         end
      end
   end

   initial begin
      stim_row_type s;
      int           counted;
      int           r;
      logic [7:0]   pick;

      for (int i = 0; i < hbp_pkg::NUM_SYMBOLS; i++) code_mem[i] = '0;

      directed_rows = '{
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_FLUSH,  8'd0,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(CMD_RESERVED,        8'd5,   10'h3FF, 4'd10, 1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd0,   10'h3FF, 4'd15, 1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hFF, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hFF, 8'h00),
         make_row(hbp_pkg::CMD_FLUSH,  8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hF0, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd255, 10'h000, 4'd8,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd255, 10'h000, 4'd0,  1'b1, 2'd1, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd1,   10'h3FF, 4'd3,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd1,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hFF, 8'h00),
         make_row(hbp_pkg::CMD_FLUSH,  8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hF8, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd2,   10'h02A, 4'd6,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd2,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd2, 8'hAB, 8'hFF),
         make_row(hbp_pkg::CMD_LOAD,   8'd3,   10'h07F, 4'd7,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd3,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_FLUSH,  8'd0,   10'h000, 4'd0,  1'b1, 2'd1, 8'hFE, 8'h00),
         make_row(CMD_RESERVED,        8'd0,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd0,   10'h3FF, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd0,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_FLUSH,  8'd0,   10'h000, 4'd0,  1'b1, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_LOAD,   8'd4,   10'h155, 4'd9,  1'b0, 2'd0, 8'h00, 8'h00),
         make_row(hbp_pkg::CMD_ENCODE, 8'd4,   10'h000, 4'd0,  1'b0, 2'd0, 8'h00, 8'h00)
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            pick = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                                : 8'($urandom_range(0, 255));
            s = make_row(hbp_pkg::CMD_ENCODE, pick, 10'($urandom), 4'($urandom), 1'b0, 2'd0,
                         8'h00, 8'h00);
            if (r < 12) begin
               s.cmd = hbp_pkg::CMD_LOAD;
               if ($urandom_range(0, 99) < 80) s.code_len = 4'($urandom_range(1, 10));
            end else if (r < 85) begin
               s.cmd = hbp_pkg::CMD_ENCODE;
            end else if (r < 97) begin
               s.cmd = hbp_pkg::CMD_FLUSH;
            end else begin
               s.cmd = CMD_RESERVED;
            end
            send_item(s);
            if (s.cmd != CMD_RESERVED) counted++;
            // Hold the sender off once until the output side has drained.
            if (phase == 1 && counted == ITEMS_PER_PHASE / 2) begin
               req_tvalid <= 1'b0;
               while (expected_bytes.size() != 0) @(negedge clock);
               @(negedge clock);
            end
         end
         req_tvalid <= 1'b0;
         while (expected_bytes.size() != 0) @(negedge clock);
         repeat (4) @(negedge clock);
      end

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
